// File: hw/rtl/cave_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cave_pkg
// Shared widths, types, register codes and helpers of the cave generation step
// ----------------------------------------------------------------------------
package cave_pkg;

	// grid geometry
	localparam int ROW_CELLS = 64;
	localparam int LEN_W     = 7;
	localparam int LIMIT_W   = 4;
	localparam int COUNT_W   = 4;

	// configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// output queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [ROW_CELLS-1:0] row_t;
	typedef logic [LIMIT_W-1:0]   limit_t;
	typedef logic [LEN_W-1:0]     len_t;
	typedef logic [COUNT_W-1:0]   count_t;
	typedef logic [1:0]           reg_idx_t;

	// register indexes
	localparam reg_idx_t REG_SURVIVE_MIN = 2'd0;
	localparam reg_idx_t REG_FILL_ABOVE  = 2'd1;
	localparam reg_idx_t REG_ROW_LENGTH  = 2'd2;

	// register reset values
	localparam limit_t DEATH_RESET   = 4'd3;
	localparam limit_t BIRTH_RESET   = 4'd4;
	localparam len_t   ROW_LEN_RESET = 7'd64;

	typedef struct packed {
		row_t cells;
		logic last;
	} result_t;

	// up to two results written into the output queue per accepted row
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	// cells in use: length 0 acts as 1, lengths past the row act as full row
	function automatic row_t used_mask(input len_t row_length);
		len_t n;
		row_t mask;
		n = row_length;
		if (n == len_t'(0))
			n = len_t'(1);
		else if (n > len_t'(ROW_CELLS))
			n = len_t'(ROW_CELLS);
		for (int i = 0; i < ROW_CELLS; i++)
			mask[i] = len_t'(i) < n;
		return mask;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/cave_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cave_in_if
// Row channel into the block: one grid row per request
// ----------------------------------------------------------------------------
interface cave_in_if
	import cave_pkg::*;
();
	logic valid;
	logic ready;
	row_t row_cells;
	logic last_row;

	modport source (output valid, output row_cells, output last_row, input ready);
	modport sink   (input valid, input row_cells, input last_row, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/cave_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cave_out_if
// Result channel out of the block: one next-generation row per request
// ----------------------------------------------------------------------------
interface cave_out_if
	import cave_pkg::*;
();
	logic valid;
	logic ready;
	row_t next_row_cells;
	logic last_out;

	modport source (output valid, output next_row_cells, output last_out, input ready);
	modport sink   (input valid, input next_row_cells, input last_out, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/cave_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cave_lane
// One cell: counts the walls among its eight neighbours and applies the rule
// ----------------------------------------------------------------------------
module cave_lane
	import cave_pkg::*;
(
	input  wire logic [2:0] up,
	input  wire logic [1:0] side,
	input  wire logic [2:0] down,
	input  wire logic       center,
	input  wire limit_t     survive_min,
	input  wire limit_t     fill_above,
	output logic            wall
);

	count_t cnt;

	// neighbour wall count, 0..8
	always_comb begin
		cnt = count_t'(up[0]) + count_t'(up[1]) + count_t'(up[2])
			+ count_t'(side[0]) + count_t'(side[1])
			+ count_t'(down[0]) + count_t'(down[1]) + count_t'(down[2]);
	end

	// walls survive at or above the death limit, open cells fill above birth
	always_comb begin
		if (center)
			wall = cnt >= survive_min;
		else
			wall = cnt > fill_above;
	end

endmodule
`default_nettype wire

// File: hw/rtl/cave_gen.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cave_gen
// One row of cell lanes side by side, merged into the next-generation row
// ----------------------------------------------------------------------------
module cave_gen
	import cave_pkg::*;
(
	input  wire row_t   up,
	input  wire row_t   mid,
	input  wire row_t   down,
	input  wire row_t   used,
	input  wire limit_t survive_min,
	input  wire limit_t fill_above,
	output row_t        next_row
);

	logic [ROW_CELLS+1:0] up_ext;
	logic [ROW_CELLS+1:0] mid_ext;
	logic [ROW_CELLS+1:0] down_ext;
	row_t                 lane_wall;

	// unused cells and both row ends read as outside walls
	assign up_ext   = {1'b1, up   | ~used, 1'b1};
	assign mid_ext  = {1'b1, mid  | ~used, 1'b1};
	assign down_ext = {1'b1, down | ~used, 1'b1};

	// one lane per cell
	for (genvar i = 0; i < ROW_CELLS; i++) begin : g_lane
		cave_lane u_lane (
			.up          (up_ext[i+2:i]),
			.side        ({mid_ext[i+2], mid_ext[i]}),
			.down        (down_ext[i+2:i]),
			.center      (mid_ext[i+1]),
			.survive_min (survive_min),
			.fill_above  (fill_above),
			.wall        (lane_wall[i])
		);
	end

	// merge lanes, cells past the row length are cleared
	assign next_row = lane_wall & used;

endmodule
`default_nettype wire

// File: hw/rtl/cave_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cave_out_queue
// Small result queue: takes up to two a cycle, sends out one per ready cycle
// ----------------------------------------------------------------------------
module cave_out_queue
	import cave_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       room,
	cave_out_if.source result
);

	result_t            entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QCNT_W-1:0]  count_q;
	logic               pop;
	logic [QPTR_W-1:0]  wr_next;

	// room for a full pair of results
	assign room    = count_q <= QCNT_W'(QUEUE_DEPTH - 2);
	assign pop     = result.valid && result.ready;
	assign wr_next = wr_q + QPTR_W'(1);

	assign result.valid          = count_q != '0;
	assign result.next_row_cells = entries_q[rd_q].cells;
	assign result.last_out       = entries_q[rd_q].last;

	// payload storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			entries_q[wr_q] <= push.first;
		if (push.count == 2'd2)
			entries_q[wr_next] <= push.second;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QPTR_W'(push.count);
			if (pop)
				rd_q <= rd_q + QPTR_W'(1);
			count_q <= count_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

	// fill level stays within the queue
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("result queue overfilled");

	// results are only written when a pair fits
	assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> room)
		else $error("result written without room");

	// a waiting result holds still
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid
			&& $stable(result.next_row_cells) && $stable(result.last_out))
		else $error("waiting result changed");

endmodule
`default_nettype wire

// File: hw/rtl/cave_automaton_generation_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cave_automaton_generation_step
// One generation of the cave smoothing automaton over a streamed binary grid
// ----------------------------------------------------------------------------
// The block takes one grid row per cycle on grid and returns next-generation
// rows on result. A row's result is computed by 64 parallel cell lanes in the
// cycle that the row below it is accepted and is registered in the queue;
// a final row yields two results at once (one for a lone row) into a
// four-entry queue that sends one row a cycle while result is ready. The grid
// channel drops ready only while fewer than two queue entries are free, which
// happens only when the result side stalls; with result ready held high rows
// are taken every cycle. Limits and the row length sit in APB registers at
// byte addresses 0, 4 and 8 and should be written only between grids.
// ----------------------------------------------------------------------------
module cave_automaton_generation_step
	import cave_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	cave_in_if.sink                 grid,
	cave_out_if.source              result
);

	limit_t   survive_min_q;
	limit_t   fill_above_q;
	len_t     row_length_q;
	row_t     above_q;
	row_t     middle_q;
	logic     mid_valid_q;
	reg_idx_t reg_idx;
	logic     cfg_write;
	logic     accept;
	logic     room;
	row_t     used;
	row_t     gen_a_up;
	row_t     gen_a_mid;
	row_t     gen_a_down;
	row_t     gen_a;
	row_t     gen_b;
	push_t    push;

	// configuration registers
	assign pready    = 1'b1;
	assign reg_idx   = paddr[PADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			survive_min_q <= DEATH_RESET;
			fill_above_q  <= BIRTH_RESET;
			row_length_q  <= ROW_LEN_RESET;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_SURVIVE_MIN: survive_min_q <= pwdata[LIMIT_W-1:0];
				REG_FILL_ABOVE:  fill_above_q  <= pwdata[LIMIT_W-1:0];
				REG_ROW_LENGTH:  row_length_q  <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			REG_SURVIVE_MIN: prdata = PDATA_W'(survive_min_q);
			REG_FILL_ABOVE:  prdata = PDATA_W'(fill_above_q);
			REG_ROW_LENGTH:  prdata = PDATA_W'(row_length_q);
			default:         prdata = '0;
		endcase
	end

	// row handshake
	assign grid.ready = room;
	assign accept     = grid.valid && grid.ready;
	assign used       = used_mask(row_length_q);

	// first generator: middle row, or a lone row between walls
	assign gen_a_up   = mid_valid_q ? above_q   : '1;
	assign gen_a_mid  = mid_valid_q ? middle_q  : grid.row_cells;
	assign gen_a_down = mid_valid_q ? grid.row_cells : '1;

	cave_gen u_gen_a (
		.up          (gen_a_up),
		.mid         (gen_a_mid),
		.down        (gen_a_down),
		.used        (used),
		.survive_min (survive_min_q),
		.fill_above  (fill_above_q),
		.next_row    (gen_a)
	);

	// second generator: the final row with walls below
	cave_gen u_gen_b (
		.up          (middle_q),
		.mid         (grid.row_cells),
		.down        ('1),
		.used        (used),
		.survive_min (survive_min_q),
		.fill_above  (fill_above_q),
		.next_row    (gen_b)
	);

	// results into the queue
	always_comb begin
		push.first.cells  = gen_a;
		push.first.last   = !mid_valid_q;
		push.second.cells = gen_b;
		push.second.last  = 1'b1;
		priority if (!accept)
			push.count = 2'd0;
		else if (mid_valid_q)
			push.count = grid.last_row ? 2'd2 : 2'd1;
		else
			push.count = grid.last_row ? 2'd1 : 2'd0;
	end

	cave_out_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.result (result)
	);

	// row window, cleared at the end of each grid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q     <= '1;
			middle_q    <= '0;
			mid_valid_q <= 1'b0;
		end else if (accept) begin
			if (grid.last_row) begin
				above_q     <= '1;
				middle_q    <= '0;
				mid_valid_q <= 1'b0;
			end else begin
				if (mid_valid_q)
					above_q <= middle_q;
				middle_q    <= grid.row_cells;
				mid_valid_q <= 1'b1;
			end
		end
	end

	// a final row leaves the window as after reset
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && grid.last_row |=> !mid_valid_q && (above_q == '1))
		else $error("grid window not cleared after final row");

	// a first row that is not final is held as the middle row
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && !mid_valid_q && !grid.last_row |=> mid_valid_q)
		else $error("first row not held");

	// readback carries no bits above the widest register
	assert property (@(posedge clk) disable iff (!arst_n)
		prdata[PDATA_W-1:LEN_W] == '0)
		else $error("readback upper bits set");

endmodule
`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cave generation step: streams grids of rows,
// writes the limits and the row length over APB between grids, and compares every
// next-generation row against fixed rows or a bench-side cellular automaton model
// ----------------------------------------------------------------------------
module tb_top;
	import cave_pkg::*;

	localparam int N_DIRECTED  = 24;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AFTER  = 150;
	localparam int N_PHASES    = 10;
	localparam int PHASE_ROWS  = 100;
	localparam int MAX_REPORTS = 10;

	// one directed row, optionally preceded by a register update
	typedef struct {
		logic   set_cfg;
		limit_t death;
		limit_t birth;
		len_t   len;
		row_t   cells;
		logic   last;
		logic   typed;
		row_t   exp_cells;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	cave_in_if  grid_if ();
	cave_out_if result_if ();

	// bench copy of the registers and of the row window
	limit_t cfg_death;
	limit_t cfg_birth;
	len_t   cfg_len;
	row_t   grid_above;
	row_t   grid_middle;
	logic   middle_held;

	result_t pending_rows [$];
	int      errors;
	int      results_seen;
	logic    steady;

	dir_row_t directed [N_DIRECTED] = '{
		'{1'b0, 4'd3, 4'd4, 7'd64, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
		'{1'b0, 4'd3, 4'd4, 7'd64, 64'h0000_0000_0000_0000, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
		'{1'b0, 4'd3, 4'd4, 7'd64, 64'h0000_0000_0000_0000, 1'b0, 1'b0, 64'h0},
		'{1'b0, 4'd3, 4'd4, 7'd64, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'h0},
		'{1'b0, 4'd3, 4'd4, 7'd64, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 64'h0},
		'{1'b0, 4'd3, 4'd4, 7'd64, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 64'h0},
		'{1'b0, 4'd3, 4'd4, 7'd64, 64'h0000_0001_8000_0000, 1'b0, 1'b0, 64'h0},
		'{1'b0, 4'd3, 4'd4, 7'd64, 64'h8000_0000_0000_0001, 1'b1, 1'b0, 64'h0},
		'{1'b1, 4'd0, 4'd0, 7'd64, 64'h0000_0000_0000_0000, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
		'{1'b0, 4'd0, 4'd0, 7'd64, 64'hDEAD_BEEF_0123_4567, 1'b0, 1'b0, 64'h0},
		'{1'b0, 4'd0, 4'd0, 7'd64, 64'h0F0F_0F0F_0F0F_0F0F, 1'b1, 1'b0, 64'h0},
		'{1'b1, 4'd9, 4'd8, 7'd64, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'h0},
		'{1'b0, 4'd9, 4'd8, 7'd64, 64'h0000_0000_0000_0000, 1'b1, 1'b1, 64'h0},
		'{1'b1, 4'd15, 4'd15, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'h0},
		'{1'b1, 4'd3, 4'd4, 7'd1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b1, 64'h1},
		'{1'b1, 4'd3, 4'd4, 7'd127, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
		'{1'b0, 4'd3, 4'd4, 7'd127, 64'h1234_5678_9ABC_DEF0, 1'b0, 1'b0, 64'h0},
		'{1'b0, 4'd3, 4'd4, 7'd127, 64'hFEDC_BA98_7654_3210, 1'b1, 1'b0, 64'h0},
		'{1'b1, 4'd5, 4'd3, 7'd63, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 64'h0},
		'{1'b0, 4'd5, 4'd3, 7'd63, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
		'{1'b0, 4'd5, 4'd3, 7'd63, 64'h0000_0000_0000_0000, 1'b1, 1'b0, 64'h0},
		'{1'b1, 4'd4, 4'd5, 7'd65, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
		'{1'b1, 4'd3, 4'd4, 7'd2, 64'h0000_0000_0000_0002, 1'b0, 1'b0, 64'h0},
		'{1'b0, 4'd3, 4'd4, 7'd2, 64'h0000_0000_0000_0001, 1'b1, 1'b0, 64'h0}
	};

	cave_automaton_generation_step uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.grid    (grid_if),
		.result  (result_if)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// cell value with everything outside the used row counting as wall
	function automatic int cell_of(input row_t row, input int j, input int n);
		if (j < 0 || j >= n)
			return 1;
		return int'(row[j]);
	endfunction

	// one generation of the middle row given its upper and lower neighbours
	function automatic row_t next_generation(input row_t up, input row_t mid, input row_t down);
		int   n;
		int   cnt;
		row_t res;
		n = (cfg_len == 0) ? 1 : ((int'(cfg_len) > ROW_CELLS) ? ROW_CELLS : int'(cfg_len));
		res = '0;
		for (int i = 0; i < n; i++) begin
			cnt = 0;
			for (int d = -1; d <= 1; d++) begin
				cnt += cell_of(up, i + d, n) + cell_of(down, i + d, n);
				if (d != 0)
					cnt += cell_of(mid, i + d, n);
			end
			if (mid[i])
				res[i] = cnt >= int'(cfg_death);
			else
				res[i] = cnt > int'(cfg_birth);
		end
		return res;
	endfunction

	function automatic void clear_window();
		grid_above  = '1;
		grid_middle = '0;
		middle_held = 1'b0;
	endfunction

	// advance the row window by one accepted row and queue what it yields
	function automatic void predict_row(input row_t cells, input logic last,
			input logic typed, input row_t typed_cells);
		result_t r;
		if (!middle_held) begin
			if (last) begin
				r.cells = typed ? typed_cells : next_generation('1, cells, '1);
				r.last  = 1'b1;
				pending_rows.insert(pending_rows.size(), r);
				clear_window();
			end else begin
				grid_middle = cells;
				middle_held = 1'b1;
			end
		end else begin
			r.cells = next_generation(grid_above, grid_middle, cells);
			r.last  = 1'b0;
			pending_rows.insert(pending_rows.size(), r);
			grid_above  = grid_middle;
			grid_middle = cells;
			if (last) begin
				r.cells = next_generation(grid_above, grid_middle, '1);
				r.last  = 1'b1;
				pending_rows.insert(pending_rows.size(), r);
				clear_window();
			end
		end
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("mismatch %s at %0t: expected %h got %h", what, $realtime, want, got);
	endtask

	// offer one row, with random gaps unless steady, and predict once it is taken
	task automatic send_row(input row_t cells, input logic last, input logic typed,
			input row_t typed_cells);
		@(negedge clk);
		while (!steady && $urandom_range(99) < 29) begin
			grid_if.valid <= 1'b0;
			@(negedge clk);
		end
		grid_if.valid     <= 1'b1;
		grid_if.row_cells <= cells;
		grid_if.last_row  <= last;
		@(posedge clk);
		while (!grid_if.ready)
			@(posedge clk);
		predict_row(cells, last, typed, typed_cells);
	endtask

	// drain every result, then let the pipeline settle
	task automatic wait_idle();
		@(negedge clk);
		grid_if.valid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write with junk in the unused bits, then read back
	task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
		logic [PDATA_W-1:0] keep;
		logic [PDATA_W-1:0] data;
		keep = (idx == REG_ROW_LENGTH) ? 32'h7F : 32'hF;
		data = ($urandom() & ~keep) | (value & keep);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== (value & keep))
			note_mismatch("register readback", 64'(value & keep), 64'(prdata));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_SURVIVE_MIN: cfg_death = limit_t'(value & keep);
			REG_FILL_ABOVE:  cfg_birth = limit_t'(value & keep);
			REG_ROW_LENGTH:  cfg_len   = len_t'(value & keep);
			default: ;
		endcase
	endtask

	task automatic set_config(input limit_t death, input limit_t birth, input len_t len);
		write_reg(REG_SURVIVE_MIN, PDATA_W'(death));
		write_reg(REG_FILL_ABOVE, PDATA_W'(birth));
		write_reg(REG_ROW_LENGTH, PDATA_W'(len));
	endtask

	// result receiver: random stalls unless steady, plus one long hold-off
	initial begin
		logic held;
		held = 1'b0;
		result_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				result_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			result_if.ready <= steady || ($urandom_range(99) >= 29);
		end
	end

	// compare each result request with the oldest expected row
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			results_seen++;
			if (pending_rows.size() == 0) begin
				note_mismatch("unexpected row", 64'h0, result_if.next_row_cells);
			end else begin
				want = pending_rows.pop_front();
				if (result_if.next_row_cells !== want.cells)
					note_mismatch("next_row_cells", want.cells, result_if.next_row_cells);
				if (result_if.last_out !== want.last)
					note_mismatch("last_out", 64'(want.last), 64'(result_if.last_out));
			end
		end
	end

	// watchdog on cycles without any request or register access
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((grid_if.valid && grid_if.ready) || (result_if.valid && result_if.ready) || psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("** cave_automaton_generation_step: FAILED **");
		$finish;
	end

	// stimulus
	initial begin
		int   rows_sent;
		int   nrows;
		limit_t death;
		limit_t birth;
		len_t len;
		row_t cells;

		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		grid_if.valid     = 1'b0;
		grid_if.row_cells = '0;
		grid_if.last_row  = 1'b0;
		errors            = 0;
		results_seen      = 0;
		steady            = 1'b0;
		cfg_death         = DEATH_RESET;
		cfg_birth         = BIRTH_RESET;
		cfg_len           = ROW_LEN_RESET;
		clear_window();

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// directed rows
		for (int k = 0; k < N_DIRECTED; k++) begin
			if (directed[k].set_cfg) begin
				wait_idle();
				set_config(directed[k].death, directed[k].birth, directed[k].len);
			end
			send_row(directed[k].cells, directed[k].last, directed[k].typed,
				directed[k].exp_cells);
		end

		// random grids, one register setting per phase
		for (int p = 0; p < N_PHASES; p++) begin
			wait_idle();
			steady = (p == 3 || p == 4);
			case ($urandom_range(5))
				0:       death = 4'd0;
				1:       death = limit_t'($urandom_range(15, 9));
				2:       death = 4'd8;
				default: death = limit_t'($urandom_range(5, 2));
			endcase
			case ($urandom_range(4))
				0:       birth = 4'd0;
				1:       birth = limit_t'($urandom_range(15, 8));
				default: birth = limit_t'($urandom_range(6, 3));
			endcase
			case ($urandom_range(7))
				0:       len = 7'd0;
				1:       len = 7'd1;
				2:       len = 7'd64;
				3:       len = len_t'($urandom_range(127, 65));
				4:       len = 7'd3;
				default: len = len_t'($urandom_range(64, 1));
			endcase
			set_config(death, birth, len);
			rows_sent = 0;
			while (rows_sent < PHASE_ROWS) begin
				nrows = ($urandom_range(3) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
				for (int r = 0; r < nrows; r++) begin
					case ($urandom_range(5))
						0:       cells = {$urandom(), $urandom()} & {$urandom(), $urandom()};
						1:       cells = {$urandom(), $urandom()} | {$urandom(), $urandom()};
						2:       cells = $urandom_range(1) ? '1 : '0;
						default: cells = {$urandom(), $urandom()};
					endcase
					send_row(cells, r == nrows - 1, 1'b0, '0);
				end
				rows_sent += nrows;
			end
		end
		steady = 1'b0;

		// drain and settle
		@(negedge clk);
		grid_if.valid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("** cave_automaton_generation_step: PASSED **");
		else
			$display("** cave_automaton_generation_step: FAILED **");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/cave_pkg.sv
hw/rtl/cave_in_if.sv
hw/rtl/cave_out_if.sv
hw/rtl/cave_lane.sv
hw/rtl/cave_gen.sv
hw/rtl/cave_out_queue.sv
hw/rtl/cave_automaton_generation_step.sv
test/tb_top.sv
